FILE: rtl/branch_target_buffer_lru_top_assert.svh
// Assertion macros for the branch target buffer checker.
`ifndef BRANCH_TARGET_BUFFER_LRU_TOP_ASSERT_SVH
`define BRANCH_TARGET_BUFFER_LRU_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, quiet while in reset
`define BTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |-> cons) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, quiet while in reset
`define BTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error(msg);

`endif

FILE: rtl/btb_lru_pkg.sv
// Shared types, constants and functions for the branch target buffer.
package btb_lru_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;

    // request opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // two-bit hysteresis counter states
    localparam logic [1:0] CNT_SNT = 2'd0;
    localparam logic [1:0] CNT_WNT = 2'd1;
    localparam logic [1:0] CNT_WT  = 2'd2;
    localparam logic [1:0] CNT_ST  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } t_state;

    // search token handed from cell to cell
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [IDX_W-1:0]   hit_idx;
        logic               pred;
        logic [ADDR_W-1:0]  target;
        logic [STAMP_W-1:0] best_stamp;
        logic [IDX_W-1:0]   best_idx;
    } t_carry;

    // write command broadcast to every cell
    typedef struct packed {
        logic               en_stamp;
        logic               en_upd;
        logic               en_alloc;
        logic [IDX_W-1:0]   idx;
        logic [STAMP_W-1:0] stamp;
        logic [ADDR_W-1:0]  tag;
        logic [ADDR_W-1:0]  target;
        logic               taken;
    } t_wcmd;

    function automatic logic [1:0] next_counter(input logic [1:0] cnt, input logic taken);
        logic [1:0] res;
        case (cnt)
            CNT_ST:  res = taken ? CNT_ST : CNT_WT;
            CNT_WT:  res = taken ? CNT_ST : CNT_SNT;
            CNT_WNT: res = taken ? CNT_ST : CNT_SNT;
            default: res = taken ? CNT_WNT : CNT_SNT;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/btb_lru_cell.sv
// One buffer entry with its stage of the tag search and LRU victim scan.
module btb_lru_cell import btb_lru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_carry            i_carry,
    input  t_wcmd             i_wcmd,
    output t_carry            o_carry
);

    logic               r_valid;
    logic [ADDR_W-1:0]  r_tag;
    logic [1:0]         r_cnt;
    logic [ADDR_W-1:0]  r_target;
    logic [STAMP_W-1:0] r_last_use;
    t_carry             r_carry;
    t_carry             n_carry;
    logic               match;
    logic               sel;

    // first hit wins; strictly smaller stamp takes the victim slot
    always_comb begin
        match   = r_valid && (r_tag == i_addr);
        n_carry = i_carry;
        if (!i_carry.hit && match) begin
            n_carry.hit     = 1'b1;
            n_carry.hit_idx = i_idx;
            n_carry.pred    = (r_cnt >= CNT_WT);
            n_carry.target  = r_target;
        end
        if (r_last_use < i_carry.best_stamp) begin
            n_carry.best_stamp = r_last_use;
            n_carry.best_idx   = i_idx;
        end
    end

    // token register towards the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.vld <= 1'b0;
        end else begin
            r_carry <= n_carry;
        end
    end

    assign o_carry = r_carry;

    // entry write on commit
    assign sel = (i_wcmd.idx == i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_cnt      <= CNT_SNT;
            r_last_use <= '0;
        end else if (sel) begin
            if (i_wcmd.en_stamp) begin
                r_last_use <= i_wcmd.stamp;
            end
            if (i_wcmd.en_upd) begin
                r_target <= i_wcmd.target;
                r_cnt    <= next_counter(r_cnt, i_wcmd.taken);
            end
            if (i_wcmd.en_alloc) begin
                r_valid    <= 1'b1;
                r_tag      <= i_wcmd.tag;
                r_last_use <= i_wcmd.stamp;
                r_target   <= i_wcmd.target;
                r_cnt      <= i_wcmd.taken ? CNT_ST : CNT_SNT;
            end
        end
    end

endmodule

FILE: rtl/branch_target_buffer_lru_top.sv
// Fully associative branch target buffer with LRU replacement, top level.
// One request at a time. A request walks a row of ENTRIES cells, one cell per
// cycle, each cell matching its tag and folding its last-use stamp into the
// running LRU minimum; the result is then written back and presented. No new
// request is accepted until the write-back, which waits while a stalled
// consumer holds the result register. Stall on the input side stays high
// from acceptance until the write-back.
module branch_target_buffer_lru_top import btb_lru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [ADDR_W-1:0] i_branch_addr,
    input  logic [STAMP_W-1:0] i_stamp,
    input  logic              i_taken,
    input  logic [ADDR_W-1:0] i_new_target,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_hit,
    output logic              o_predict_taken,
    output logic [ADDR_W-1:0] o_predicted_target
);

    t_state             r_state;
    t_state             n_state;
    logic               accept;
    logic               commit;
    logic               r_start;
    logic               r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_taken;
    logic [ADDR_W-1:0]  r_target;
    t_carry             r_res;
    t_carry             w_carry [ENTRIES+1];
    t_wcmd              wcmd;
    logic               r_out_valid;
    logic               r_hit;
    logic               r_pred;
    logic [ADDR_W-1:0]  r_pred_target;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        commit     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_rst_n;
                if (i_in_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_carry[ENTRIES].vld) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                commit = !r_out_valid || !i_out_stall;
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    // request register and start pulse into the cell row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_addr   <= i_branch_addr;
            r_stamp  <= i_stamp;
            r_taken  <= i_taken;
            r_target <= i_new_target;
        end
    end

    // head of the search token: no hit, no candidate below all-ones
    always_comb begin
        w_carry[0]            = '0;
        w_carry[0].vld        = r_start;
        w_carry[0].best_stamp = '1;
    end

    // row of cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        btb_lru_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_addr  (r_addr),
            .i_carry (w_carry[g]),
            .i_wcmd  (wcmd),
            .o_carry (w_carry[g+1])
        );
    end

    // token from the end of the row, held until write-back
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SEARCH && w_carry[ENTRIES].vld) begin
            r_res <= w_carry[ENTRIES];
        end
    end

    // write-back command
    always_comb begin
        wcmd.en_stamp = commit && (r_op == OP_LOOKUP) && r_res.hit;
        wcmd.en_upd   = commit && (r_op == OP_UPDATE) && r_res.hit;
        wcmd.en_alloc = commit && (r_op == OP_UPDATE) && !r_res.hit;
        wcmd.idx      = r_res.hit ? r_res.hit_idx : r_res.best_idx;
        wcmd.stamp    = r_stamp;
        wcmd.tag      = r_addr;
        wcmd.target   = r_target;
        wcmd.taken    = r_taken;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit  <= r_res.hit;
            r_pred <= (r_op == OP_LOOKUP) && r_res.hit && r_res.pred;
            if ((r_op == OP_LOOKUP) && r_res.hit && r_res.pred) begin
                r_pred_target <= r_res.target;
            end else begin
                r_pred_target <= '0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hit              = r_hit;
    assign o_predict_taken    = r_pred;
    assign o_predicted_target = r_pred_target;

endmodule

FILE: rtl/btb_lru_chk.sv
// Port-level checker for the branch target buffer, bound to the top level.
`include "branch_target_buffer_lru_top_assert.svh"

module btb_lru_chk import btb_lru_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_hit,
    input logic               o_predict_taken,
    input logic [ADDR_W-1:0]  o_predicted_target
);

    // a stalled result holds
    `BTB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_predicted_target) && $stable(o_hit) && $stable(o_predict_taken), "stalled result changed")

    // taken prediction only on a hit
    `BTB_ASSERT_NOW(a_pred_hit, o_out_valid && o_predict_taken, o_hit, "taken prediction without hit")

    // target is zero unless predicted taken
    `BTB_ASSERT_NOW(a_tgt_zero, o_out_valid && !o_predict_taken, o_predicted_target == '0, "target not zero without taken prediction")

    // one request in flight: stall rises right after acceptance
    `BTB_ASSERT_NEXT(a_one_req, i_in_valid && !o_in_stall, o_in_stall, "second request taken while busy")

endmodule

bind branch_target_buffer_lru_top btb_lru_chk u_btb_lru_chk (.*);

FILE: verif/branch_target_buffer_lru_top_tb.sv
// Self-checking testbench for the LRU branch target buffer, with its own prediction of the block.
module branch_target_buffer_lru_top_tb import btb_lru_pkg::*; ();

    localparam int POOL_SIZE   = 20;      // more addresses than entries, so evictions happen
    localparam int HOLD_CYCLES = 400;     // long consumer hold-off
    localparam int CYCLE_LIMIT = 250000;
    localparam int TAIL_CYCLES = 4 * ENTRIES;

    typedef struct packed {
        logic               opcode;
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
        logic               taken;
        logic [ADDR_W-1:0]  target;
    } btb_req_t;

    typedef struct packed {
        logic              hit;
        logic              pred;
        logic [ADDR_W-1:0] target;
    } btb_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_opcode = OP_LOOKUP;
    logic [ADDR_W-1:0]  i_branch_addr = '0;
    logic [STAMP_W-1:0] i_stamp = '0;
    logic               i_taken = 1'b0;
    logic [ADDR_W-1:0]  i_new_target = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_hit;
    logic               o_predict_taken;
    logic [ADDR_W-1:0]  o_predicted_target;

    // predicted contents of the buffer
    logic               mdl_valid    [ENTRIES];
    logic [ADDR_W-1:0]  mdl_tag      [ENTRIES];
    logic [1:0]         mdl_cnt      [ENTRIES];
    logic [ADDR_W-1:0]  mdl_target   [ENTRIES];
    logic [STAMP_W-1:0] mdl_last_use [ENTRIES];

    btb_req_t           pending_req_q[$];
    btb_result_t        pred_result_q[$];
    logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
    logic [STAMP_W-1:0] stamp_clock;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int req_accepted  = 0;
    int hold_reqs     = 0;
    int hold_done     = 0;
    int hold_left     = 0;
    int fault_cnt     = 0;
    int cycle_cnt     = 0;

    branch_target_buffer_lru_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_branch_addr      (i_branch_addr),
        .i_stamp            (i_stamp),
        .i_taken            (i_taken),
        .i_new_target       (i_new_target),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hit              (o_hit),
        .o_predict_taken    (o_predict_taken),
        .o_predicted_target (o_predicted_target)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected result of one request; advances the predicted buffer state
    function automatic btb_result_t btb_predict(input btb_req_t rq);
        btb_result_t r;
        int          hit_at;
        int          victim;
        r = '0;
        hit_at = -1;
        // lowest matching index among valid entries
        for (int k = ENTRIES - 1; k >= 0; k--) begin
            if (mdl_valid[k] && mdl_tag[k] == rq.addr) hit_at = k;
        end
        if (rq.opcode == OP_LOOKUP) begin
            if (hit_at >= 0) begin
                r.hit = 1'b1;
                mdl_last_use[hit_at] = rq.stamp;
                if (mdl_cnt[hit_at] == CNT_WT || mdl_cnt[hit_at] == CNT_ST) begin
                    r.pred   = 1'b1;
                    r.target = mdl_target[hit_at];
                end
            end
        end else if (hit_at >= 0) begin
            // update hit: new target, counter steps, stamp left alone
            r.hit = 1'b1;
            mdl_target[hit_at] = rq.target;
            case (mdl_cnt[hit_at])
                CNT_ST:  mdl_cnt[hit_at] = rq.taken ? CNT_ST : CNT_WT;
                CNT_SNT: mdl_cnt[hit_at] = rq.taken ? CNT_WNT : CNT_SNT;
                default: mdl_cnt[hit_at] = rq.taken ? CNT_ST : CNT_SNT;
            endcase
        end else begin
            // update miss: oldest stamp goes, valid bit not considered
            victim = 0;
            for (int k = 1; k < ENTRIES; k++) begin
                if (mdl_last_use[k] < mdl_last_use[victim]) victim = k;
            end
            mdl_valid[victim]    = 1'b1;
            mdl_tag[victim]      = rq.addr;
            mdl_last_use[victim] = rq.stamp;
            mdl_target[victim]   = rq.target;
            mdl_cnt[victim]      = rq.taken ? CNT_ST : CNT_SNT;
        end
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic     load;
        btb_req_t rq;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            for (int k = 0; k < ENTRIES; k++) begin
                mdl_valid[k]    = 1'b0;
                mdl_tag[k]      = '0;
                mdl_cnt[k]      = CNT_SNT;
                mdl_target[k]   = '0;
                mdl_last_use[k] = '0;
            end
        end else begin
            load = !i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                rq.opcode = i_opcode;
                rq.addr   = i_branch_addr;
                rq.stamp  = i_stamp;
                rq.taken  = i_taken;
                rq.target = i_new_target;
                pred_result_q.push_back(btb_predict(rq));
                req_accepted++;
                load = 1'b1;
            end
            if (load) begin
                if (pending_req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    rq = pending_req_q.pop_front();
                    i_opcode      <= rq.opcode;
                    i_branch_addr <= rq.addr;
                    i_stamp       <= rq.stamp;
                    i_taken       <= rq.taken;
                    i_new_target  <= rq.target;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and consumer stall
    always @(posedge i_clk) begin
        btb_result_t got;
        btb_result_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.hit    = o_hit;
                got.pred   = o_predict_taken;
                got.target = o_predicted_target;
                if (pred_result_q.size() == 0) begin
                    if (fault_cnt < 10)
                        $display("unexpected result: hit=%0b pred=%0b target=%h",
                                 got.hit, got.pred, got.target);
                    fault_cnt++;
                end else begin
                    want = pred_result_q.pop_front();
                    if (got.hit !== want.hit || got.pred !== want.pred ||
                        got.target !== want.target) begin
                        if (fault_cnt < 10)
                            $display({"mismatch: expected hit=%0b pred=%0b target=%h,",
                                      " got hit=%0b pred=%0b target=%h"},
                                     want.hit, want.pred, want.target,
                                     got.hit, got.pred, got.target);
                        fault_cnt++;
                    end
                end
            end
            if (hold_done != hold_reqs) begin
                hold_left = HOLD_CYCLES;
                hold_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_req(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [STAMP_W-1:0] stamp, input logic taken,
                             input logic [ADDR_W-1:0] target);
        btb_req_t rq;
        rq.opcode = op;
        rq.addr   = addr;
        rq.stamp  = stamp;
        rq.taken  = taken;
        rq.target = target;
        pending_req_q.push_back(rq);
    endtask

    // mostly pooled addresses and rising stamps, some ties and wild values
    task automatic queue_random(input int n);
        btb_req_t rq;
        int       sel;
        for (int j = 0; j < n; j++) begin
            rq.opcode = $urandom_range(1) ? OP_UPDATE : OP_LOOKUP;
            sel = $urandom_range(99);
            rq.addr = (sel < 85) ? addr_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
            sel = $urandom_range(99);
            if (sel < 3) begin
                rq.stamp = $urandom;
            end else if (sel < 10) begin
                rq.stamp = stamp_clock;
            end else begin
                stamp_clock += $urandom_range(40, 1);
                rq.stamp = stamp_clock;
            end
            rq.taken  = 1'($urandom_range(1));
            rq.target = $urandom;
            pending_req_q.push_back(rq);
        end
    endtask

    // sender pause until every outstanding request has answered
    task automatic wait_drain();
        while (pending_req_q.size() != 0 || i_in_valid || pred_result_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) addr_pool[k] = $urandom;
        stamp_clock = 32'd100;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 48;

        // empty buffer: reset tags must not hit, all-ones neither
        queue_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        // allocate strong taken, then walk the counter through all states
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0005, 1'b0, 32'h0000_0000);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0006, 1'b0, 32'h1234_5678);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0007, 1'b0, 32'h0000_0000);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0008, 1'b0, 32'h8765_4321);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0009, 1'b0, 32'h0000_0000);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_000A, 1'b1, 32'hA5A5_A5A5);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_000B, 1'b0, 32'h0000_0000);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_000C, 1'b0, 32'h5A5A_5A5A);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_000D, 1'b1, 32'h0F0F_0F0F);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_000E, 1'b1, 32'hF0F0_F0F0);
        queue_req(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_000F, 1'b1, 32'hDEAD_BEEF);
        queue_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0010, 1'b1, 32'h0000_0000);
        // allocate not taken at stamp zero; ties with the invalid entries
        queue_req(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
        queue_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000);
        // lowest index with stamp zero is the valid one, so it is evicted
        queue_req(OP_UPDATE, 32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001);
        queue_req(OP_LOOKUP, 32'h0000_0000, 32'h0000_0011, 1'b0, 32'h0000_0000);
        queue_req(OP_LOOKUP, 32'h0000_0001, 32'h0000_0012, 1'b0, 32'h0000_0000);
        // update hit leaves the stamp; the next allocation goes to a stamp-zero invalid entry
        queue_req(OP_UPDATE, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 32'h8000_0000);
        queue_req(OP_UPDATE, 32'h0000_0002, 32'h0000_0013, 1'b1, 32'h0000_0002);
        queue_req(OP_LOOKUP, 32'h0000_0001, 32'h0000_0014, 1'b0, 32'h0000_0000);
        queue_req(OP_LOOKUP, 32'h0000_0002, 32'h0000_0015, 1'b0, 32'h0000_0000);

        queue_random(220);
        // long consumer hold-off while requests keep coming
        while (req_accepted < 40) @(posedge i_clk);
        hold_reqs++;
        wait_drain();

        send_idle_pct = 48;
        recv_idle_pct = 25;
        queue_random(230);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(230);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pred_result_q.size() != 0) begin
            if (fault_cnt < 10)
                $display("%0d expected results never arrived", pred_result_q.size());
            fault_cnt++;
        end
        if (fault_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
